// File: src/aesd_pkg.sv
// Shared types and constants for the AES-256 block decrypt core.
// No dependencies; imported by the round datapath and the top level of the core.
package aesd_pkg;

   localparam int BLOCK_W    = 128;
   localparam int KEY_COUNT  = 15;
   localparam int KEY_AW     = 4;
   localparam int LAST_ROUND = 14;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } fsm_state_type;

   typedef enum logic [1:0] {
      RK_FIRST,
      RK_MID,
      RK_LAST
   } round_kind_type;

   typedef struct packed {
      round_kind_type kind;
   } round_ctrl_type;

endpackage

// File: src/aesd_ram.sv
// Generic single-clock RAM, one write port, one read port, registered read.
// No dependencies.
module aesd_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 15,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/aesd_round.sv
// One inverse-cipher round step, chosen by round kind: add key, optional inverse
// mix columns, optional inverse shift rows and inverse S-box. Depends on aesd_pkg.
module aesd_round (
   input  aesd_pkg::round_ctrl_type          ctrl,
   input  logic [aesd_pkg::BLOCK_W-1:0]      blk_in,
   input  logic [aesd_pkg::BLOCK_W-1:0]      round_key,
   output logic [aesd_pkg::BLOCK_W-1:0]      blk_out
);
   import aesd_pkg::*;

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
      8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
      8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
      8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
      8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
      8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
      8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
      8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
      8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
      8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
      8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
      8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
      8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
      8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
      8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
      8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
      8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
      8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
      8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
      8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
      8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
      8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
      8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
      8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
      8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
      8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
      8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
      8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
      8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
      8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
      8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
      8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
   };

   // multiply by x in GF(2^8)
   function automatic logic [7:0] xt(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at the top for i = 0
   function automatic logic [127:0] shift_sub(input logic [127:0] s);
      logic [127:0] t;
      int src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = 4 * ((c - r) & 3) + r;
            t[127 - 8 * (4 * c + r) -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a  [4];
      logic [7:0]   x2 [4];
      logic [7:0]   x4 [4];
      logic [7:0]   x8 [4];
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a[r]  = s[127 - 8 * (4 * c + r) -: 8];
            x2[r] = xt(a[r]);
            x4[r] = xt(x2[r]);
            x8[r] = xt(x4[r]);
         end
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] =
               (x8[r] ^ x4[r] ^ x2[r]) ^                                  // *14
               (x8[(r + 1) & 3] ^ x2[(r + 1) & 3] ^ a[(r + 1) & 3]) ^     // *11
               (x8[(r + 2) & 3] ^ x4[(r + 2) & 3] ^ a[(r + 2) & 3]) ^     // *13
               (x8[(r + 3) & 3] ^ a[(r + 3) & 3]);                        // *9
         end
      end
      return t;
   endfunction

   logic [BLOCK_W-1:0] keyed;

   assign keyed = blk_in ^ round_key;

   always_comb begin
      unique case (ctrl.kind)
         RK_FIRST: blk_out = shift_sub(keyed);
         RK_MID:   blk_out = shift_sub(inv_mix(keyed));
         RK_LAST:  blk_out = keyed;
         default:  blk_out = keyed;
      endcase
   end

endmodule

// File: src/aes256_block_decrypt.sv
// Top level of the AES-256 block decrypt core: round key RAM, sequencer,
// round datapath and result register. Depends on aesd_pkg, aesd_ram, aesd_round.
//
//  channel | direction | tdata (low bits first)          | tuser (low bits first)
//  req     | in        | data_hi[63:0], data_lo[127:64]   | mode[0], key_slot[4:1]
//  rsp     | out       | plain_hi[63:0], plain_lo[127:64] | -
//
// A key load writes one round key; a load to slot 15 is dropped.
// A decrypt starts the read of key 14 with the transaction, then runs one round per
// cycle for keys 14 down to 0, except while the last round holds (see below).
// The sequencer then returns to idle; no request is accepted while a decrypt runs.
// Reset clears the sequencer and the result valid; the key RAM is not cleared.
// A decrypt holds in its last round until the previous result is taken.
module aes256_block_decrypt (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // data_hi[63:0], data_lo[127:64]
   input  logic [4:0]   req_tuser,   // mode[0], key_slot[4:1]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // plain_hi[63:0], plain_lo[127:64]
);
   import aesd_pkg::*;

   fsm_state_type      state_ff, state_in;
   logic [KEY_AW-1:0]  rnd_ff, rnd_in;
   logic [BLOCK_W-1:0] blk_ff, blk_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_data_ff, rsp_data_in;

   logic               req_fire;
   logic               req_mode;
   logic [KEY_AW-1:0]  req_slot;
   logic [BLOCK_W-1:0] req_blk;      // byte 0 at the top
   logic               out_free;
   logic               advance;

   logic               key_wr_en;
   logic [KEY_AW-1:0]  key_rd_addr;
   logic [BLOCK_W-1:0] round_key;
   round_ctrl_type     round_ctrl;
   logic [BLOCK_W-1:0] round_out;

   assign req_mode = req_tuser[0];
   assign req_slot = req_tuser[4:1];
   assign req_blk  = {req_tdata[63:0], req_tdata[127:64]};
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // write a round key only for a valid slot
   assign key_wr_en = req_fire && (req_mode == MODE_LOAD) &&
                      (req_slot < KEY_AW'(KEY_COUNT));

   aesd_ram #(
      .WIDTH (BLOCK_W),
      .DEPTH (KEY_COUNT)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (req_slot),
      .wr_data (req_blk),
      .rd_addr (key_rd_addr),
      .rd_data (round_key)
   );

   aesd_round u_round (
      .ctrl      (round_ctrl),
      .blk_in    (blk_ff),
      .round_key (round_key),
      .blk_out   (round_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in        = state_ff;
      rnd_in          = rnd_ff;
      blk_in          = blk_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      req_tready      = 1'b0;
      advance         = 1'b0;
      key_rd_addr     = rnd_ff;
      round_ctrl.kind = RK_MID;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            // start the read of the first round key with the transaction
            key_rd_addr = KEY_AW'(LAST_ROUND);
            if (req_fire && (req_mode == MODE_DECRYPT)) begin
               state_in = ST_RUN;
               rnd_in   = KEY_AW'(LAST_ROUND);
               blk_in   = req_blk;
            end
         end
         ST_RUN: begin
            if (rnd_ff == KEY_AW'(LAST_ROUND)) begin
               round_ctrl.kind = RK_FIRST;
            end else if (rnd_ff == '0) begin
               round_ctrl.kind = RK_LAST;
            end else begin
               round_ctrl.kind = RK_MID;
            end

            if (rnd_ff == '0) begin
               // hold the final key add until the result register is free
               if (out_free) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {round_out[63:0], round_out[127:64]};
               end
            end else begin
               advance     = 1'b1;
               blk_in      = round_out;
               rnd_in      = rnd_ff - KEY_AW'(1);
               key_rd_addr = rnd_ff - KEY_AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // the round counter never runs past the last round key
   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (rnd_ff <= KEY_AW'(LAST_ROUND)))
      else $error("round counter out of range");

   // each advancing round steps the counter down by one
   a_rnd_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rnd_ff == $past(rnd_ff) - KEY_AW'(1)) && (state_ff == ST_RUN))
      else $error("round counter did not step");

   // a result appears only after the final key add
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid && !rsp_tready)) |->
         $past(state_ff == ST_RUN && rnd_ff == '0))
      else $error("result without a finished decrypt");

   // key RAM is never written while a decrypt reads it
   a_no_wr_in_run: assert property (@(posedge clock) disable iff (reset)
      key_wr_en |-> (state_ff == ST_IDLE))
      else $error("key write during decrypt");
`endif

endmodule

// File: dv/aes256_block_decrypt_checker.sv
// Checker for the AES-256 block decrypt core: tracks round key loads, predicts
// each plaintext block and compares it with the rsp channel. Depends on aesd_pkg.
`timescale 1ns / 100ps

module aes256_block_decrypt_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,   // data_hi[63:0], data_lo[127:64]
   input  logic [4:0]   req_tuser,   // mode[0], key_slot[4:1]
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,   // plain_hi[63:0], plain_lo[127:64]
   output int           mismatch_count,
   output int           pending_results,
   output int           checked_blocks
);
   import aesd_pkg::*;

   typedef struct packed {
      logic [63:0] plain_hi;
      logic [63:0] plain_lo;
   } plain_block_type;

   // round key k as {bytes 0..7, bytes 8..15}, byte 0 topmost
   logic [127:0]    round_keys [KEY_COUNT];
   logic [7:0]      inv_sbox [256];
   plain_block_type plaintext_queue [$];

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] prod, x;
      prod = 8'd0;
      x    = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) prod ^= x;
         x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
      end
      return prod;
   endfunction

   // byte i of a block sits at bits 127-8i down
   function automatic plain_block_type inverse_cipher(input logic [127:0] cipher);
      logic [127:0] st, nx;
      logic [7:0]   col [4];
      st = cipher;
      for (int rnd = LAST_ROUND; rnd >= 1; rnd--) begin
         st = st ^ round_keys[rnd];
         if (rnd < LAST_ROUND) begin
            nx = st;
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) col[r] = st[127 - 8*(4*c + r) -: 8];
               for (int r = 0; r < 4; r++)
                  nx[127 - 8*(4*c + r) -: 8] = gf_mul(col[r], 8'd14)
                                             ^ gf_mul(col[(r + 1) % 4], 8'd11)
                                             ^ gf_mul(col[(r + 2) % 4], 8'd13)
                                             ^ gf_mul(col[(r + 3) % 4], 8'd9);
            end
            st = nx;
         end
         // inverse shift rows folded into the inverse S-box lookup
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               nx[127 - 8*(4*c + r) -: 8] = inv_sbox[st[127 - 8*(4*((c - r + 4) % 4) + r) -: 8]];
         st = nx;
      end
      st = st ^ round_keys[0];
      return plain_block_type'(st);
   endfunction

   initial begin : build_inv_sbox
      logic [7:0] inv, sub;
      for (int x = 0; x < 256; x++) begin
         inv = 8'd1;
         for (int e = 0; e < 254; e++) inv = gf_mul(inv, 8'(x));
         if (x == 0) inv = 8'd0;
         sub = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                   ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         inv_sbox[sub] = 8'(x);
      end
   end

   always @(posedge clock) begin : monitor
      logic            mode;
      logic [3:0]      slot;
      logic [63:0]     data_hi, data_lo;
      plain_block_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            mode    = req_tuser[0];
            slot    = req_tuser[4:1];
            data_hi = req_tdata[63:0];
            data_lo = req_tdata[127:64];
            if (mode == MODE_LOAD) begin
               if (slot <= LAST_ROUND) round_keys[slot] = {data_hi, data_lo};
            end else begin
               plaintext_queue.push_back(inverse_cipher({data_hi, data_lo}));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.plain_hi = rsp_tdata[63:0];
            got.plain_lo = rsp_tdata[127:64];
            if (plaintext_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t unexpected plaintext hi %h lo %h, nothing outstanding",
                           $realtime, got.plain_hi, got.plain_lo);
            end else begin
               want = plaintext_queue.pop_front();
               checked_blocks++;
               if (got.plain_hi !== want.plain_hi || got.plain_lo !== want.plain_lo) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%t block %0d: plain_hi exp %h got %h, plain_lo exp %h got %h",
                              $realtime, checked_blocks, want.plain_hi, got.plain_hi,
                              want.plain_lo, got.plain_lo);
               end
            end
         end
         pending_results <= plaintext_queue.size();
      end
   end

endmodule

// File: dv/aes256_block_decrypt_tb.sv
// Testbench top for the AES-256 block decrypt core: clock, reset, stimulus on
// req, backpressure on rsp and the verdict. Depends on aesd_pkg and the checker.
`timescale 1ns / 100ps

module aes256_block_decrypt_tb;
   import aesd_pkg::*;

   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_WAIT  = 40;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;   // data_hi[63:0], data_lo[127:64]
   logic [4:0]   req_tuser  = '0;   // mode[0], key_slot[4:1]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;         // plain_hi[63:0], plain_lo[127:64]

   // knobs for the sender and the receiver
   int   src_idle_pct   = 0;
   int   sink_stall_pct = 0;
   logic long_hold_req  = 1'b0;

   int mismatch_count, pending_results, checked_blocks;
   int cycle_count      = 0;
   int key_load_count   = 0;
   int spare_load_count = 0;
   int decrypt_count    = 0;

   aes256_block_decrypt DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   aes256_block_decrypt_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .checked_blocks  (checked_blocks)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // corner values: zero, all ones, alternating bits, single bit set or clear
   function automatic logic [63:0] corner64();
      logic [63:0] one_hot;
      one_hot = 64'd1 << $urandom_range(0, 63);
      unique case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return '1;
         2: return 64'haaaa_aaaa_aaaa_aaaa;
         3: return 64'h5555_5555_5555_5555;
         4: return one_hot;
         default: return ~one_hot;
      endcase
   endfunction

   // Offer one transaction and hold it until req accepts it. An optional idle
   // burst goes in front; valid stays high straight into the next transaction.
   task automatic send_txn(input logic mode, input logic [3:0] slot,
                           input logic [63:0] data_hi, input logic [63:0] data_lo);
      if ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {data_lo, data_hi};
      req_tuser  <= {slot, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (mode == MODE_DECRYPT)
         decrypt_count++;
      else if (slot > LAST_ROUND)
         spare_load_count++;
      else
         key_load_count++;
   endtask

   // Drop valid and hold until every predicted block has come back. The first
   // edge lets the checker see the last accepted transaction.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Mostly decrypts of random blocks under the current keys, with key updates
   // mixed in (single slots and whole new key sets) so later blocks use new
   // keys. Loads to slot 15 are noise and do not count toward the total.
   task automatic random_txns(input int count);
      int done, pick, base;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            send_txn(MODE_DECRYPT, 4'($urandom_range(0, 15)), rand64(), rand64());
            done++;
         end else if (pick < 80) begin
            send_txn(MODE_DECRYPT, 4'($urandom_range(0, 15)), corner64(), corner64());
            done++;
         end else if (pick < 92) begin
            if (pick < 85)
               send_txn(MODE_LOAD, 4'($urandom_range(0, LAST_ROUND)), corner64(), corner64());
            else
               send_txn(MODE_LOAD, 4'($urandom_range(0, LAST_ROUND)), rand64(), rand64());
            done++;
         end else if (pick < 95) begin
            // whole new key set, written from a random starting slot
            base = $urandom_range(0, LAST_ROUND);
            for (int k = 0; k < KEY_COUNT; k++)
               send_txn(MODE_LOAD, 4'((base + k) % KEY_COUNT), rand64(), rand64());
            done += KEY_COUNT;
         end else begin
            send_txn(MODE_LOAD, 4'd15, rand64(), rand64());
         end
      end
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_done) begin
            hold_done  = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               CYCLE_LIMIT, pending_results);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: load every round key before any decrypt, since the key
      // store holds garbage until written. Slot 0 all zeros, slot 14 all ones.
      src_idle_pct   = 20;
      sink_stall_pct = 4;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (k == 0)
            send_txn(MODE_LOAD, 4'(k), 64'd0, 64'd0);
         else if (k == LAST_ROUND)
            send_txn(MODE_LOAD, 4'(k), '1, '1);
         else
            send_txn(MODE_LOAD, 4'(k), rand64(), rand64());
      end
      // slot 15 is out of range: the block must drop it
      send_txn(MODE_LOAD, 4'd15, rand64(), rand64());
      // key_slot is ignored on a decrypt, so vary it across the extremes
      send_txn(MODE_DECRYPT, 4'd0, 64'd0, 64'd0);
      send_txn(MODE_DECRYPT, 4'd15, '1, '1);
      send_txn(MODE_DECRYPT, 4'd7, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      send_txn(MODE_DECRYPT, 4'd14, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_txn(MODE_DECRYPT, 4'($urandom_range(0, 15)), rand64(), rand64());
      // rewrite the last key and decrypt right behind it: the new key applies at once
      send_txn(MODE_LOAD, 4'd0, rand64(), rand64());
      send_txn(MODE_DECRYPT, 4'd1, 64'd0, 64'd0);

      random_txns(400);

      // Long receiver hold while decrypts keep coming: the block fills up and
      // must stall req. Then pause the sender until every result is out.
      src_idle_pct  = 0;
      long_hold_req <= 1'b1;
      for (int k = 0; k < 40; k++)
         send_txn(MODE_DECRYPT, 4'($urandom_range(0, 15)), rand64(), rand64());
      wait_idle();

      // stretch with no idling at all, then heavy idling on both sides
      sink_stall_pct = 0;
      random_txns(350);
      src_idle_pct   = 40;
      sink_stall_pct = 10;
      random_txns(600);
      wait_idle();

      // last part runs flat out
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      random_txns(235);

      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Summary: %0d round key loads plus %0d to slot 15, %0d block decrypts",
               key_load_count, spare_load_count, decrypt_count);
      $display("Summary: %0d plaintext blocks compared, %0d mismatches, %0d cycles",
               checked_blocks, mismatch_count, cycle_count);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
